[hw/rtl/add_pkg.sv]
// Shared widths, register indexes, types and the square-root step for the
// anchor distance difference block. Depends on nothing else.
package add_pkg;

   // Coordinate and fraction widths; the other widths but LEN_W follow from them.
   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 8;
   localparam int LEN_W      = 26;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int RAD_W      = SUM_W + 2 * FRAC_BITS;
   localparam int ROOT_W     = (RAD_W + 1) / 2;
   localparam int RAD_PAD_W  = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int DELTA_W    = ROOT_W + 1;

   // Middle queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANCHOR_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANCHOR_Y = 2'd1;

   typedef struct packed {
      logic [SUM_W-1:0] sum_origin;
      logic [SUM_W-1:0] sum_dest;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [RAD_PAD_W-1:0] rad;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
   } sqrt_state_type;

   // Magnitude of the difference of two signed coordinates.
   function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                   logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      if (d < 0) begin
         d = -d;
      end
      return d[COORD_W-1:0];
   endfunction

   // One restoring step of the square root: brings down the next pair of
   // radicand bits and decides one root bit.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      sqrt_state_type n;
      logic [REM_W-1:0] cand;
      logic [REM_W-1:0] trial;
      cand  = {s.rem[REM_W-3:0], s.rad[RAD_PAD_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      n.rad = {s.rad[RAD_PAD_W-3:0], 2'b00};
      if (cand >= trial) begin
         n.rem  = cand - trial;
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = cand;
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

[hw/rtl/add_front.sv]
// Front end: anchor registers, input acceptance, coordinate differences and
// squares. Depends on add_pkg; feeds the middle queue (add_queue).
module add_front
   import add_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [COORD_W-1:0]     req_origin_x,
   input  logic [COORD_W-1:0]     req_origin_y,
   input  logic [COORD_W-1:0]     req_dest_x,
   input  logic [COORD_W-1:0]     req_dest_y,
   input  q_status_type           q_status,
   output logic                   q_push,
   output pair_type               q_data
);

   logic [COORD_W-1:0] anchor_x_ff;
   logic [COORD_W-1:0] anchor_y_ff;

   logic               diff_valid_ff;
   logic [COORD_W-1:0] dox_ff, doy_ff, ddx_ff, ddy_ff;
   logic               sq_valid_ff;
   logic [SQ_W-1:0]    sox_ff, soy_ff, sdx_ff, sdy_ff;
   logic               advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANCHOR_X: anchor_x_ff <= csr_data;
            CSR_ANCHOR_Y: anchor_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The two stages move together; they hold only when the squares cannot
   // leave into the queue.
   assign advance  = !(sq_valid_ff && q_status.full);
   assign req_full = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
      end else if (advance) begin
         diff_valid_ff <= req_push;
         sq_valid_ff   <= diff_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dox_ff <= abs_diff(req_origin_x, anchor_x_ff);
         doy_ff <= abs_diff(req_origin_y, anchor_y_ff);
         ddx_ff <= abs_diff(req_dest_x, anchor_x_ff);
         ddy_ff <= abs_diff(req_dest_y, anchor_y_ff);
         sox_ff <= SQ_W'(dox_ff) * SQ_W'(dox_ff);
         soy_ff <= SQ_W'(doy_ff) * SQ_W'(doy_ff);
         sdx_ff <= SQ_W'(ddx_ff) * SQ_W'(ddx_ff);
         sdy_ff <= SQ_W'(ddy_ff) * SQ_W'(ddy_ff);
      end
   end

   assign q_push            = sq_valid_ff && !q_status.full;
   assign q_data.sum_origin = SUM_W'(sox_ff) + SUM_W'(soy_ff);
   assign q_data.sum_dest   = SUM_W'(sdx_ff) + SUM_W'(sdy_ff);

endmodule

[hw/rtl/add_queue.sv]
// Short queue of squared distances between the front end and the root
// pipeline. Depends on add_pkg.
module add_queue
   import add_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pair_type     push_data,
   input  logic         pop,
   output pair_type     pop_data,
   output q_status_type status
);

   pair_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");

endmodule

[hw/rtl/add_sqrt.sv]
// Pipelined integer square root, one root bit per stage, for the origin and
// destination radicands side by side. Depends on add_pkg.
module add_sqrt
   import add_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  pair_type          in_sums,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root_origin,
   output logic [ROOT_W-1:0] out_root_dest
);

   sqrt_state_type stage_o_ff [ROOT_W];
   sqrt_state_type stage_d_ff [ROOT_W];
   logic           valid_ff   [ROOT_W];
   sqrt_state_type init_o;
   sqrt_state_type init_d;

   // The fractional bits come from scaling the radicand by four per bit.
   assign init_o.rad  = RAD_PAD_W'(in_sums.sum_origin) << (2 * FRAC_BITS);
   assign init_o.rem  = '0;
   assign init_o.root = '0;
   assign init_d.rad  = RAD_PAD_W'(in_sums.sum_dest) << (2 * FRAC_BITS);
   assign init_d.rem  = '0;
   assign init_d.root = '0;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (advance) begin
               valid_ff[i] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               stage_o_ff[i] <= sqrt_step(init_o);
               stage_d_ff[i] <= sqrt_step(init_d);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (advance) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               stage_o_ff[i] <= sqrt_step(stage_o_ff[i-1]);
               stage_d_ff[i] <= sqrt_step(stage_d_ff[i-1]);
            end
         end
      end
   end

   assign out_valid       = valid_ff[ROOT_W-1];
   assign out_root_origin = stage_o_ff[ROOT_W-1].root;
   assign out_root_dest   = stage_d_ff[ROOT_W-1].root;

endmodule

[hw/rtl/add_back.sv]
// Back end: drains the middle queue through the root pipeline, forms the
// length difference and buffers results. Depends on add_pkg and add_sqrt.
module add_back
   import add_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  q_status_type     q_status,
   input  pair_type         q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [LEN_W-1:0] rsp_length_delta
);

   logic                      advance;
   logic                      root_valid;
   logic [ROOT_W-1:0]         root_origin;
   logic [ROOT_W-1:0]         root_dest;
   logic signed [DELTA_W-1:0] delta;

   logic [LEN_W-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             obuf_full;
   logic             do_write;
   logic             do_read;

   // The whole pipeline holds only when a finished result finds the output
   // buffer full.
   assign obuf_full = (count_ff == 2'd2);
   assign advance   = !(root_valid && obuf_full);
   assign q_pop     = advance && !q_status.empty;

   add_sqrt u_sqrt (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (!q_status.empty),
      .in_sums         (q_data),
      .out_valid       (root_valid),
      .out_root_origin (root_origin),
      .out_root_dest   (root_dest)
   );

   assign delta = $signed({1'b0, root_origin}) - $signed({1'b0, root_dest});

   assign do_write  = root_valid && advance;
   assign do_read   = rsp_pop && !rsp_empty;
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_length_delta = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_write) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_read) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= LEN_W'(delta);
      end
   end

   a_obuf_no_overflow: assert property (@(posedge clock) disable iff (reset)
      do_write |-> !obuf_full)
      else $error("output buffer written while full");

endmodule

[hw/rtl/anchor_distance_difference_top.sv]
// Top level of the anchor distance difference block.
// Depends on add_pkg, add_front, add_queue and add_back.
//
// For every move item (origin and destination points) the block returns one
// item holding the distance from the origin to the anchor point minus the
// distance from the destination to the anchor, each distance truncated to
// eight fractional bits, as a signed value with eight fractional bits. The
// anchor is written through the csr_ port (index 0 for x, index 1 for y,
// other indexes are ignored) and should only be changed while no items are
// in flight. The block sustains one item per clock cycle in both directions
// while results are popped as they come. An item passes from acceptance to
// the result ports through the front-end stages for the coordinate
// differences and squares, the middle queue, the square-root pipeline (one
// root bit per stage) and the output buffer. The front end and the root
// pipeline stall independently of each other through the four-entry middle
// queue, and the two-entry output buffer lets new items be accepted while a
// finished result waits to be taken.
module anchor_distance_difference_top
   import add_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [COORD_W-1:0]     req_origin_x,
   input  logic [COORD_W-1:0]     req_origin_y,
   input  logic [COORD_W-1:0]     req_dest_x,
   input  logic [COORD_W-1:0]     req_dest_y,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [LEN_W-1:0]       rsp_length_delta
);

   // Squared distances travel from the front end to the root pipeline
   // through the middle queue.
   logic         q_push;
   pair_type     q_push_data;
   logic         q_pop;
   pair_type     q_pop_data;
   q_status_type q_status;

   add_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_dest_x   (req_dest_x),
      .req_dest_y   (req_dest_y),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   add_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // The back end drains the queue, takes both roots and keeps results in
   // its output buffer until they are popped.
   add_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_length_delta (rsp_length_delta)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("middle queue read while empty");

endmodule

[sim/anchor_distance_difference_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for anchor_distance_difference_top: checks every cable-length
// change against a predictor kept in step with the anchor registers.
// Depends on add_pkg and the RTL of the block; it needs no other file.
module anchor_distance_difference_top_tb;
   import add_pkg::*;

   // These quiet cycles after the last expected item make sure that nothing
   // is left in flight before the anchor is changed or the run is closed.
   localparam int DRAIN_CYCLES   = 40;
   // Cycles without any accepted item before the run is declared stuck. The
   // slowest correct stretch is a receiver that stalls with a chance of 81
   // percent, which never comes close to this.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_MOVES   = 100;

   // Extremes of a coordinate, and the two register indexes that the block
   // has to ignore.
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_ZERO = '0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COORD_W-1:0]     csr_data;
   logic                   req_push;
   logic                   req_full;
   logic [COORD_W-1:0]     req_origin_x;
   logic [COORD_W-1:0]     req_origin_y;
   logic [COORD_W-1:0]     req_dest_x;
   logic [COORD_W-1:0]     req_dest_y;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [LEN_W-1:0]       rsp_length_delta;

   // The predictor's own copy of the anchor, updated at the same edge as the
   // block's registers.
   logic signed [COORD_W-1:0] anchor_x_now;
   logic signed [COORD_W-1:0] anchor_y_now;

   // Cable-length changes that the block still owes, oldest first.
   logic [LEN_W-1:0] length_deltas_due[$];

   int send_idle_pct;
   int pop_stall_pct;
   int mismatch_count;
   int moves_sent;
   int deltas_checked;
   int anchor_writes;
   int quiet_cycles;

   anchor_distance_difference_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_length_delta (rsp_length_delta)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Floor of the square root of a 64-bit value, decided one bit pair at a
   // time from the top.
   function automatic longint unsigned floor_root(longint unsigned radicand);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned bit_pair;
      rest     = radicand;
      root     = 0;
      bit_pair = 64'd1 << 62;
      while (bit_pair > rest) begin
         bit_pair = bit_pair >> 2;
      end
      while (bit_pair != 0) begin
         if (rest >= root + bit_pair) begin
            rest = rest - (root + bit_pair);
            root = (root >> 1) + bit_pair;
         end else begin
            root = root >> 1;
         end
         bit_pair = bit_pair >> 2;
      end
      return root;
   endfunction

   // Distance from a point to the anchor with FRAC_BITS fractional bits,
   // truncated: the root of the squared distance scaled by 4^FRAC_BITS.
   function automatic longint unsigned anchor_distance(logic signed [COORD_W-1:0] px,
                                                       logic signed [COORD_W-1:0] py);
      longint signed   span_x;
      longint signed   span_y;
      longint unsigned squared;
      span_x  = longint'(px) - longint'(anchor_x_now);
      span_y  = longint'(py) - longint'(anchor_y_now);
      squared = longint'(span_x * span_x) + longint'(span_y * span_y);
      return floor_root(squared << (2 * FRAC_BITS));
   endfunction

   function automatic logic [LEN_W-1:0] predict_length_delta(logic [COORD_W-1:0] ox,
                                                             logic [COORD_W-1:0] oy,
                                                             logic [COORD_W-1:0] dx,
                                                             logic [COORD_W-1:0] dy);
      longint signed change;
      change = longint'(anchor_distance(ox, oy)) - longint'(anchor_distance(dx, dy));
      return change[LEN_W-1:0];
   endfunction

   // A random coordinate: mostly any value at all, sometimes an extreme, and
   // sometimes a point close to the anchor so that short distances, where the
   // fractional bits carry the answer, are also exercised.
   function automatic logic [COORD_W-1:0] random_coord(logic [COORD_W-1:0] near);
      logic [COORD_W-1:0] value;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(2))
               0: value = COORD_MIN;
               1: value = COORD_MAX;
               default: value = COORD_ZERO;
            endcase
         end
         1, 2: begin
            value = near + COORD_W'($urandom_range(16)) - COORD_W'(8);
         end
         default: begin
            value = COORD_W'($urandom);
         end
      endcase
      return value;
   endfunction

   // Monitor and checker. Everything is sampled at the rising edge, before
   // the block's own registers move, so the values seen are the ones the
   // handshakes were made on.
   always @(posedge clock) begin
      logic [LEN_W-1:0] due;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            anchor_writes++;
            case (csr_index)
               CSR_ANCHOR_X: anchor_x_now = csr_data;
               CSR_ANCHOR_Y: anchor_y_now = csr_data;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            length_deltas_due.push_back(predict_length_delta(req_origin_x, req_origin_y,
                                                             req_dest_x, req_dest_y));
            moves_sent++;
         end
         if (rsp_pop && !rsp_empty) begin
            deltas_checked++;
            if (length_deltas_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected item, length_delta %0d", $realtime,
                           $signed(rsp_length_delta));
               end
            end else begin
               due = length_deltas_due.pop_front();
               if (rsp_length_delta !== due) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: length_delta expected %0d, got %0d", $realtime,
                              $signed(due), $signed(rsp_length_delta));
                  end
               end
            end
         end
      end
   end

   // Watchdog: a run that stops moving items in every direction is stuck.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d items outstanding",
                  length_deltas_due.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver takes or refuses the oldest item once per cycle, as the
   // current stall rate says.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Offers one move and holds it until the block takes it. Push stays high
   // on return, so that back-to-back moves go in on consecutive cycles; the
   // next call, or wait_drained, decides at the falling edge what follows.
   task automatic send_move(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                            logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push     <= 1'b1;
      req_origin_x <= ox;
      req_origin_y <= oy;
      req_dest_x   <= dx;
      req_dest_y   <= dy;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
   endtask

   // Stops sending, lets every owed item come back and then gives the block
   // time to settle, so that the anchor may be changed safely.
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (length_deltas_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [COORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_anchor(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay);
      wait_drained();
      csr_write(CSR_ANCHOR_X, ax);
      csr_write(CSR_ANCHOR_Y, ay);
   endtask

   // With the anchor at its reset value of the origin: zero-length moves,
   // the extremes of every coordinate, and the longest possible distance.
   task automatic test_reset_anchor();
      send_move(COORD_ZERO, COORD_ZERO, COORD_ZERO, COORD_ZERO);
      send_move(COORD_MAX, COORD_ZERO, COORD_ZERO, COORD_MAX);
      send_move(COORD_MIN, COORD_ZERO, COORD_ZERO, COORD_MIN);
      send_move(COORD_MIN, COORD_MIN, COORD_ZERO, COORD_ZERO);
      send_move(COORD_ZERO, COORD_ZERO, COORD_MIN, COORD_MIN);
      send_move(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_move(COORD_W'(1), COORD_ZERO, COORD_ZERO, COORD_W'(1));
      send_move(COORD_W'(1), COORD_W'(1), COORD_ZERO, COORD_W'(1));
   endtask

   // Anchor in opposite corners of the plane, so that the coordinate
   // differences span the full range and the result reaches both of its
   // extremes.
   task automatic test_anchor_extremes();
      set_anchor(COORD_MAX, COORD_MAX);
      send_move(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_move(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_move(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      set_anchor(COORD_MIN, COORD_MIN);
      send_move(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_move(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_move(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
   endtask

   // Writes to the two indexes beyond the register list must leave the anchor
   // as it was.
   task automatic test_unknown_index();
      set_anchor(COORD_W'(100), COORD_W'(-200));
      csr_write(CSR_SPARE_LOW, COORD_MAX);
      csr_write(CSR_SPARE_HIGH, COORD_MIN);
      send_move(COORD_W'(103), COORD_W'(-196), COORD_W'(100), COORD_W'(-200));
      send_move(COORD_W'(100), COORD_W'(-199), COORD_W'(-5), COORD_W'(77));
      send_move(COORD_ZERO, COORD_ZERO, COORD_MAX, COORD_MIN);
   endtask

   // One flow-control phase of random moves about a fresh anchor. Halfway
   // through, the sender holds off until every owed item has come back, so
   // that the block is seen to run empty and start again.
   task automatic test_flow_phase(int idle_pct, int stall_pct, logic [COORD_W-1:0] ax,
                                  logic [COORD_W-1:0] ay);
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      set_anchor(ax, ay);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_MOVES; i++) begin
         if (i == RANDOM_MOVES / 2) begin
            wait_drained();
         end
         ox = random_coord(ax);
         oy = random_coord(ay);
         if ($urandom_range(9) == 0) begin
            send_move(ox, oy, ox, oy);
         end else begin
            send_move(ox, oy, random_coord(ax), random_coord(ay));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_index      = CSR_ANCHOR_X;
      csr_data       = '0;
      req_push       = 1'b0;
      req_origin_x   = '0;
      req_origin_y   = '0;
      req_dest_x     = '0;
      req_dest_y     = '0;
      rsp_pop        = 1'b0;
      anchor_x_now   = '0;
      anchor_y_now   = '0;
      send_idle_pct  = 0;
      pop_stall_pct  = 0;
      mismatch_count = 0;
      moves_sent     = 0;
      deltas_checked = 0;
      anchor_writes  = 0;
      quiet_cycles   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed moves run at full rate in both directions.
      test_reset_anchor();
      test_anchor_extremes();
      test_unknown_index();

      // Random moves under each flow-control pattern in turn: no idling, a
      // mostly idle sender, a mostly stalling receiver, and light idling on
      // both sides. The anchor moves between random places, a corner and the origin.
      test_flow_phase(0, 0, COORD_W'($urandom), COORD_W'($urandom));
      test_flow_phase(81, 0, COORD_MIN, COORD_MAX);
      test_flow_phase(0, 81, COORD_W'($urandom), COORD_W'($urandom));
      test_flow_phase(12, 12, COORD_ZERO, COORD_ZERO);

      wait_drained();
      if (length_deltas_due.size() != 0) begin
         mismatch_count++;
      end

      $display("Checked %0d length deltas for %0d moves across %0d register writes,",
               deltas_checked, moves_sent, anchor_writes);
      $display("with corner anchors, ignored indexes and four idling patterns.");
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures", mismatch_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
